// ----- rtl/core/brb_pkg.sv -----
// Shared types and constants for the burst ring buffer with read advance.
// Holds the channel payload structs, status and register codes, and the
// command and status structs between the controller and the datapath.
package brb_pkg;

  localparam int DEPTH_DEFAULT      = 1024;
  localparam int ELEM_WIDTH_DEFAULT = 32;
  localparam int MAX_WRITE_DEFAULT  = 4;
  localparam int MAX_READ_DEFAULT   = 16;

  localparam int ADVANCE_W = 11;
  localparam int COUNT_W   = 5;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 5;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_READ  = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_OVER_LIMIT = 2'd1;
  localparam logic [1:0] STATUS_NO_ROOM    = 2'd2;
  localparam logic [1:0] STATUS_NO_DATA    = 2'd3;

  localparam logic CFG_WRITE_LIMIT = 1'b0;
  localparam logic CFG_READ_LIMIT  = 1'b1;

  localparam logic [2:0] WRITE_LIMIT_RESET = 3'd4;
  localparam logic [4:0] READ_LIMIT_RESET  = 5'd16;

  typedef struct packed {
    logic                 action;
    logic [COUNT_W-1:0]   count;
    logic [DATA_W-1:0]    elem_0;
    logic [DATA_W-1:0]    elem_1;
    logic [DATA_W-1:0]    elem_2;
    logic [DATA_W-1:0]    elem_3;
    logic                 use_advance;
    logic [ADVANCE_W-1:0] advance;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              has_data;
    logic [DATA_W-1:0] data;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic latch;
    logic wr_step;
    logic rd_issue;
    logic rd_load;
    logic rsp_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic accepted;
    logic is_read;
    logic count_zero;
    logic remaining_one;
    logic slot_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/brb_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Takes only its default sizes from brb_pkg.
module brb_ram #(
  parameter int WIDTH = brb_pkg::ELEM_WIDTH_DEFAULT,
  parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/brb_datapath.sv -----
// Datapath of the burst ring buffer: item register, limits, positions,
// element store, burst cursor and the result register.
// Depends on brb_pkg and brb_ram.
module brb_datapath #(
  parameter int DEPTH      = brb_pkg::DEPTH_DEFAULT,
  parameter int ELEM_WIDTH = brb_pkg::ELEM_WIDTH_DEFAULT,
  parameter int MAX_WRITE  = brb_pkg::MAX_WRITE_DEFAULT,
  parameter int MAX_READ   = brb_pkg::MAX_READ_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  brb_pkg::req_t               req_item,
  input  logic                        cfg_valid,
  input  logic                        cfg_index,
  input  logic [brb_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        rsp_stall,
  output logic                        rsp_valid,
  output brb_pkg::rsp_t               rsp_item,
  input  brb_pkg::ctl_cmd_t           cmd,
  output brb_pkg::dp_stat_t           stat
);

  localparam int PW = $clog2(2 * DEPTH);
  localparam int SW = $clog2(DEPTH);
  localparam int CW = ((PW > brb_pkg::ADVANCE_W) ? PW : brb_pkg::ADVANCE_W) + 1;

  brb_pkg::req_t                 item;
  logic [2:0]                    write_limit;
  logic [4:0]                    read_limit;
  logic [PW-1:0]                 write_position;
  logic [PW-1:0]                 read_position;
  logic [SW-1:0]                 cursor;
  logic [brb_pkg::COUNT_W-1:0]   remaining;
  logic [1:0]                    idx;

  logic [2:0]                    wlim_eff;
  logic [4:0]                    rlim_eff;
  logic [CW-1:0]                 wp_ext;
  logic [CW-1:0]                 rp_ext;
  logic [CW-1:0]                 held;
  logic [CW-1:0]                 cnt_ext;
  logic [CW-1:0]                 adv_ext;
  logic [CW-1:0]                 move;
  logic [CW-1:0]                 rp_sum;
  logic [CW-1:0]                 wp_sum;
  logic [PW-1:0]                 rp_adv;
  logic [PW-1:0]                 wp_adv;
  logic [1:0]                    chk_status;
  logic [PW-1:0]                 start_pos;
  logic [SW-1:0]                 start_slot;
  logic [SW-1:0]                 cursor_inc;
  logic [brb_pkg::DATA_W-1:0]    elem_sel;
  logic [ELEM_WIDTH-1:0]         ram_wr_data;
  logic [ELEM_WIDTH-1:0]         ram_rd_data;
  logic                          is_read;

  always_comb begin
    is_read  = (item.action == brb_pkg::ACTION_READ);
    wlim_eff = (int'(write_limit) < MAX_WRITE) ? write_limit : 3'(MAX_WRITE);
    rlim_eff = (int'(read_limit) < MAX_READ) ? read_limit : 5'(MAX_READ);
    wp_ext   = CW'(write_position);
    rp_ext   = CW'(read_position);
    cnt_ext  = CW'(item.count);
    held     = (wp_ext >= rp_ext) ? (wp_ext - rp_ext)
                                  : (wp_ext + CW'(2 * DEPTH) - rp_ext);

    if (!is_read) begin
      if (item.count > 5'(wlim_eff)) begin
        chk_status = brb_pkg::STATUS_OVER_LIMIT;
      end else if ((cnt_ext + held) > CW'(DEPTH)) begin
        chk_status = brb_pkg::STATUS_NO_ROOM;
      end else begin
        chk_status = brb_pkg::STATUS_OK;
      end
    end else begin
      if (item.count > rlim_eff) begin
        chk_status = brb_pkg::STATUS_OVER_LIMIT;
      end else if (cnt_ext > held) begin
        chk_status = brb_pkg::STATUS_NO_DATA;
      end else begin
        chk_status = brb_pkg::STATUS_OK;
      end
    end

    adv_ext = item.use_advance ? CW'(item.advance) : cnt_ext;
    move    = (adv_ext > held) ? held : adv_ext;
    rp_sum  = rp_ext + move;
    wp_sum  = wp_ext + cnt_ext;
    rp_adv  = (rp_sum >= CW'(2 * DEPTH)) ? PW'(rp_sum - CW'(2 * DEPTH)) : PW'(rp_sum);
    wp_adv  = (wp_sum >= CW'(2 * DEPTH)) ? PW'(wp_sum - CW'(2 * DEPTH)) : PW'(wp_sum);

    start_pos  = (req_item.action == brb_pkg::ACTION_READ) ? read_position : write_position;
    start_slot = (start_pos >= PW'(DEPTH)) ? SW'(start_pos - PW'(DEPTH)) : SW'(start_pos);
    cursor_inc = (cursor == SW'(DEPTH - 1)) ? '0 : cursor + 1'b1;

    case (idx)
      2'd0:    elem_sel = item.elem_0;
      2'd1:    elem_sel = item.elem_1;
      2'd2:    elem_sel = item.elem_2;
      default: elem_sel = item.elem_3;
    endcase
    ram_wr_data = ELEM_WIDTH'(elem_sel);
  end

  assign stat.accepted      = (chk_status == brb_pkg::STATUS_OK);
  assign stat.is_read       = is_read;
  assign stat.count_zero    = (item.count == '0);
  assign stat.remaining_one = (remaining == brb_pkg::COUNT_W'(1));
  assign stat.slot_free     = !rsp_valid || !rsp_stall;

  brb_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_step),
    .wr_addr (cursor),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_issue),
    .rd_addr (cursor),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item      <= req_item;
      cursor    <= start_slot;
      remaining <= req_item.count;
      idx       <= '0;
    end else if (cmd.wr_step) begin
      cursor    <= cursor_inc;
      remaining <= remaining - 1'b1;
      idx       <= idx + 1'b1;
    end else if (cmd.rd_load) begin
      cursor    <= cursor_inc;
      remaining <= remaining - 1'b1;
    end

    if (cmd.rd_load) begin
      rsp_item.status   <= brb_pkg::STATUS_OK;
      rsp_item.has_data <= 1'b1;
      rsp_item.data     <= brb_pkg::DATA_W'(ram_rd_data);
      rsp_item.last     <= stat.remaining_one;
    end else if (cmd.rsp_load) begin
      rsp_item.status   <= chk_status;
      rsp_item.has_data <= 1'b0;
      rsp_item.data     <= '0;
      rsp_item.last     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid      <= 1'b0;
      write_limit    <= brb_pkg::WRITE_LIMIT_RESET;
      read_limit     <= brb_pkg::READ_LIMIT_RESET;
      write_position <= '0;
      read_position  <= '0;
    end else begin
      if (cmd.rd_load || cmd.rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          brb_pkg::CFG_WRITE_LIMIT: write_limit <= cfg_data[2:0];
          brb_pkg::CFG_READ_LIMIT:  read_limit  <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.rd_load && stat.remaining_one) begin
        read_position <= rp_adv;
      end else if (cmd.rsp_load && stat.accepted) begin
        if (is_read) begin
          read_position <= rp_adv;
        end else begin
          write_position <= wp_adv;
        end
      end
    end
  end

endmodule

// ----- rtl/core/brb_controller.sv -----
// Controller of the burst ring buffer: one-hot state machine that sequences
// each transaction through check, burst and response steps.
// Depends on brb_pkg.
module brb_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  brb_pkg::dp_stat_t  stat,
  output brb_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_CHECK    = 6'b000010,
    ST_WRITE    = 6'b000100,
    ST_RD_ISSUE = 6'b001000,
    ST_RD_DATA  = 6'b010000,
    ST_RESPOND  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stat.accepted || stat.count_zero) begin
          state_next = ST_RESPOND;
        end else if (stat.is_read) begin
          state_next = ST_RD_ISSUE;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr_step = 1'b1;
        if (stat.remaining_one) begin
          state_next = ST_RESPOND;
        end
      end
      ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (stat.slot_free) begin
          cmd.rd_load = 1'b1;
          state_next  = stat.remaining_one ? ST_IDLE : ST_RD_ISSUE;
        end
      end
      ST_RESPOND: begin
        if (stat.slot_free) begin
          cmd.rsp_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != ST_IDLE);

endmodule

// ----- rtl/core/burst_ring_buffer_with_read_advance.sv -----
// Top level of the burst ring buffer with read advance.
// Depends on brb_pkg, brb_controller and brb_datapath.
//
//   Channel  Handshake            Payload                 Direction
//   req      req_valid/req_stall  req_item (req_t)        in
//   rsp      rsp_valid/rsp_stall  rsp_item (rsp_t)        out
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data     in
//
// One transaction is handled at a time. A read issues the registered store read
// and then loads the element into the result register, element by element.
// Reset is synchronous; the store needs no clearing pass.
// A stalled result holds the sequencer, while a new request is still taken
// when the only work left is a result waiting in the output register.
module burst_ring_buffer_with_read_advance #(
  parameter int DEPTH      = brb_pkg::DEPTH_DEFAULT,
  parameter int ELEM_WIDTH = brb_pkg::ELEM_WIDTH_DEFAULT,
  parameter int MAX_WRITE  = brb_pkg::MAX_WRITE_DEFAULT,
  parameter int MAX_READ   = brb_pkg::MAX_READ_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  brb_pkg::req_t             req_item,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output brb_pkg::rsp_t             rsp_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [brb_pkg::CFG_W-1:0] cfg_data
);

  brb_pkg::ctl_cmd_t cmd;
  brb_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  brb_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  brb_datapath #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH),
    .MAX_WRITE  (MAX_WRITE),
    .MAX_READ   (MAX_READ)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_item  (rsp_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- rtl/core/brb_checker.sv -----
// Port-level checks for the burst ring buffer, with the bind that attaches
// them to the top level. Depends on brb_pkg.
module brb_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input brb_pkg::rsp_t rsp_item
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid && !req_stall)
    else $error("Block is not idle after reset.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("Stalled result changed or vanished.");

  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_item.has_data |-> rsp_item.last && (rsp_item.data == '0))
    else $error("Result without data is not a single final result.");

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.has_data |-> rsp_item.status == brb_pkg::STATUS_OK)
    else $error("Read element carries an error status.");

endmodule

bind burst_ring_buffer_with_read_advance brb_checker u_brb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_item  (rsp_item)
);

// ----- sim/brb_burst_checker.sv -----
// Checker for the burst ring buffer: watches the request, result and register channels,
// keeps its own copy of the ring contents and positions, and compares every result
// in order. Depends on brb_pkg for the payload structs and codes.
module brb_burst_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic                      req_stall,
  input  brb_pkg::req_t             req_item,
  input  logic                      rsp_valid,
  input  logic                      rsp_stall,
  input  brb_pkg::rsp_t             rsp_item,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [brb_pkg::CFG_W-1:0] cfg_data,
  output int                        failures,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = brb_pkg::DEPTH_DEFAULT;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int WRITE_MAX  = brb_pkg::MAX_WRITE_DEFAULT;
  localparam int READ_MAX   = brb_pkg::MAX_READ_DEFAULT;
  localparam int REPORT_MAX = 10;

  logic [brb_pkg::DATA_W-1:0]    shadow_ring [RING_DEPTH];
  logic [brb_pkg::ADVANCE_W-1:0] fill_pos;
  logic [brb_pkg::ADVANCE_W-1:0] drain_pos;
  logic [2:0]                    write_cap;
  logic [4:0]                    read_cap;
  brb_pkg::rsp_t                 expected_beats [$];
  int                            fault_total;

  function automatic brb_pkg::rsp_t status_beat(input logic [1:0] code);
    return '{status: code, has_data: 1'b0, data: '0, last: 1'b1};
  endfunction

  task automatic predict_burst(input brb_pkg::req_t r);
    logic [brb_pkg::ADVANCE_W-1:0] held;
    logic [brb_pkg::ADVANCE_W-1:0] move;
    logic [brb_pkg::DATA_W-1:0]    elems [4];
    int                            cap;
    brb_pkg::rsp_t                 beat;
    held  = fill_pos - drain_pos;
    elems = '{r.elem_0, r.elem_1, r.elem_2, r.elem_3};
    if (r.action == brb_pkg::ACTION_WRITE) begin
      cap = (write_cap < WRITE_MAX) ? write_cap : WRITE_MAX;
      if (r.count > cap) begin
        expected_beats.push_back(status_beat(brb_pkg::STATUS_OVER_LIMIT));
      end else if (r.count > RING_DEPTH - held) begin
        expected_beats.push_back(status_beat(brb_pkg::STATUS_NO_ROOM));
      end else begin
        for (int i = 0; i < r.count; i++) begin
          shadow_ring[SLOT_W'(fill_pos + i)] = elems[2'(i)];
        end
        fill_pos = fill_pos + r.count;
        expected_beats.push_back(status_beat(brb_pkg::STATUS_OK));
      end
    end else begin
      cap = (read_cap < READ_MAX) ? read_cap : READ_MAX;
      if (r.count > cap) begin
        expected_beats.push_back(status_beat(brb_pkg::STATUS_OVER_LIMIT));
      end else if (r.count > held) begin
        expected_beats.push_back(status_beat(brb_pkg::STATUS_NO_DATA));
      end else begin
        move = r.use_advance ? r.advance : brb_pkg::ADVANCE_W'(r.count);
        if (move > held) begin
          move = held;
        end
        if (r.count == 0) begin
          expected_beats.push_back(status_beat(brb_pkg::STATUS_OK));
        end
        for (int i = 0; i < r.count; i++) begin
          beat.status   = brb_pkg::STATUS_OK;
          beat.has_data = 1'b1;
          beat.data     = shadow_ring[SLOT_W'(drain_pos + i)];
          beat.last     = (i == r.count - 1);
          expected_beats.push_back(beat);
        end
        drain_pos = drain_pos + move;
      end
    end
  endtask

  task automatic check_beat(input brb_pkg::rsp_t got);
    brb_pkg::rsp_t want;
    if (expected_beats.size() == 0) begin
      fault_total++;
      if (fault_total <= REPORT_MAX) begin
        $display("%0t: result with nothing expected: status %0d has_data %0b data %h last %0b",
                 $time, got.status, got.has_data, got.data, got.last);
      end
      return;
    end
    want = expected_beats.pop_front();
    if (got.status !== want.status || got.has_data !== want.has_data ||
        got.data !== want.data || got.last !== want.last) begin
      fault_total++;
      if (fault_total <= REPORT_MAX) begin
        $display("%0t: mismatch: expected status %0d has_data %0b data %h last %0b",
                 $time, want.status, want.has_data, want.data, want.last);
        $display("%0t:           got      status %0d has_data %0b data %h last %0b",
                 $time, got.status, got.has_data, got.data, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill_pos    = '0;
      drain_pos   = '0;
      write_cap   = brb_pkg::WRITE_LIMIT_RESET;
      read_cap    = brb_pkg::READ_LIMIT_RESET;
      fault_total = 0;
      expected_beats.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        check_beat(rsp_item);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == brb_pkg::CFG_WRITE_LIMIT) begin
          write_cap = cfg_data[2:0];
        end else if (cfg_index == brb_pkg::CFG_READ_LIMIT) begin
          read_cap = cfg_data;
        end
      end
      if (req_valid && !req_stall) begin
        predict_burst(req_item);
      end
    end
    failures    <= fault_total;
    outstanding <= expected_beats.size();
  end

endmodule

// ----- sim/burst_ring_buffer_with_read_advance_tb.sv -----
// Top of the burst ring buffer testbench: clock, reset, register writes and request
// stimulus with random idling and back-pressure, and the final verdict.
// Depends on brb_pkg, the block under test and brb_burst_checker.
module burst_ring_buffer_with_read_advance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 17;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      req_valid = 1'b0;
  logic                      req_stall;
  brb_pkg::req_t             req_item  = '0;
  logic                      rsp_valid;
  logic                      rsp_stall = 1'b0;
  brb_pkg::rsp_t             rsp_item;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic                      cfg_index = 1'b0;
  logic [brb_pkg::CFG_W-1:0] cfg_data  = '0;
  int                        failures;
  int                        outstanding;
  int                        cycles    = 0;
  logic                      quiet     = 1'b0;
  logic                      hold_long = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  burst_ring_buffer_with_read_advance uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  brb_burst_checker burst_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_item    (req_item),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_item    (rsp_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        hold      = LONG_HOLD;
        hold_long = 1'b0;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 3);
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
    end
  end

  function automatic brb_pkg::req_t make_burst(input logic act, input int n,
                                               input logic by_adv, input int adv);
    brb_pkg::req_t r;
    r.action      = act;
    r.count       = brb_pkg::COUNT_W'(n);
    r.elem_0      = $urandom();
    r.elem_1      = $urandom();
    r.elem_2      = $urandom();
    r.elem_3      = $urandom();
    r.use_advance = by_adv;
    r.advance     = brb_pkg::ADVANCE_W'(adv);
    return r;
  endfunction

  function automatic brb_pkg::req_t random_burst();
    brb_pkg::req_t r;
    int            pick;
    r    = make_burst(brb_pkg::ACTION_WRITE, 0, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r.action = 1'($urandom_range(0, 1));
      r.count  = brb_pkg::COUNT_W'($urandom_range(0, 31));
    end else if (pick < 65) begin
      r.count = brb_pkg::COUNT_W'($urandom_range(1, 4));
    end else begin
      r.action  = brb_pkg::ACTION_READ;
      r.count   = brb_pkg::COUNT_W'($urandom_range(0, 16));
      r.advance = ($urandom_range(0, 3) != 0) ? brb_pkg::ADVANCE_W'($urandom_range(0, 18))
                                              : brb_pkg::ADVANCE_W'($urandom_range(0, 2047));
    end
    return r;
  endfunction

  task automatic offer(input brb_pkg::req_t item);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_item  <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!(req_valid && !req_stall));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] wcap, input logic [4:0] rcap);
    cfg_valid <= 1'b1;
    cfg_index <= brb_pkg::CFG_WRITE_LIMIT;
    cfg_data  <= {2'($urandom_range(0, 3)), wcap};
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_index <= brb_pkg::CFG_READ_LIMIT;
    cfg_data  <= rcap;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    brb_pkg::req_t item;
    logic [2:0]    wcaps [6];
    logic [4:0]    rcaps [6];
    wcaps = '{3'd4, 3'd4, 3'd2, 3'd3, 3'd1, 3'd6};
    rcaps = '{5'd16, 5'd16, 5'd5, 5'd12, 5'd1, 5'd20};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset, high, zero limits: boundaries, overlapping windows, clamped advances.
    offer(make_burst(brb_pkg::ACTION_WRITE, 0, 1'b0, 0));
    item = make_burst(brb_pkg::ACTION_WRITE, 4, 1'b1, 2047);
    item.elem_0 = '1;
    item.elem_1 = '1;
    item.elem_2 = '1;
    item.elem_3 = '1;
    offer(item);
    item = make_burst(brb_pkg::ACTION_WRITE, 4, 1'b0, 0);
    item.elem_0 = '0;
    item.elem_1 = '0;
    item.elem_2 = '0;
    item.elem_3 = '0;
    offer(item);
    offer(make_burst(brb_pkg::ACTION_WRITE, 3, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_WRITE, 5, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_WRITE, 31, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_READ, 17, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_READ, 16, 1'b1, 2));
    offer(make_burst(brb_pkg::ACTION_READ, 0, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_WRITE, 4, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_WRITE, 1, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_READ, 16, 1'b1, 2));
    offer(make_burst(brb_pkg::ACTION_READ, 4, 1'b1, 0));
    offer(make_burst(brb_pkg::ACTION_READ, 4, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_READ, 0, 1'b1, 3));
    offer(make_burst(brb_pkg::ACTION_READ, 2, 1'b1, 2047));
    offer(make_burst(brb_pkg::ACTION_READ, 1, 1'b0, 0));
    wait_drained();
    configure(3'd7, 5'd31);
    offer(make_burst(brb_pkg::ACTION_WRITE, 4, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_WRITE, 5, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_READ, 31, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_READ, 4, 1'b0, 0));
    wait_drained();
    configure(3'd0, 5'd0);
    offer(make_burst(brb_pkg::ACTION_WRITE, 0, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_WRITE, 1, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_READ, 0, 1'b0, 0));
    offer(make_burst(brb_pkg::ACTION_READ, 1, 1'b0, 0));

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      configure(wcaps[3'(p)], rcaps[3'(p)]);
      quiet = (p == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 6) begin
          hold_long = 1'b1;
        end
        if (p == 1 && k == 14) begin
          wait_drained();
        end
        offer(random_burst());
      end
    end

    quiet = 1'b0;
    wait_drained();
    configure(3'd4, 5'd16);
    offer(make_burst(brb_pkg::ACTION_READ, 0, 1'b1, 1024));
    offer(make_burst(brb_pkg::ACTION_READ, 1, 1'b0, 0));

    wait_drained();
    if (failures == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
